// File: rtl/pphd_pkg.sv
// Shared constants and types for the peak-hold PWM duty block.
// Used by the controller, the datapath and the top level; depends on nothing.
package pphd_pkg;

   localparam int CHANNELS     = 6;
   localparam int DUTY_BITS    = 8;
   localparam int CH_BITS      = 3;
   localparam int BYTE_BITS    = 8;
   localparam int CD_BITS      = 16;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SYNC_BYTE      = 1'd1;

   localparam logic [CD_BITS-1:0]   RESET_INTERVAL = 16'd80;
   localparam logic [BYTE_BITS-1:0] RESET_SYNC     = 8'hFE;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_BYTE = 1'b1;

   typedef struct packed {
      logic accept;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic pend_any;
      logic out_full;
      logic out_taken;
   } sts_type;

endpackage

// File: rtl/pphd_ctrl.sv
// Controller state machine for the peak-hold PWM duty block.
// Depends on pphd_pkg; drives the datapath through cmd_type and reads sts_type.
module pphd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pphd_pkg::sts_type sts,
   output pphd_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.emit_load = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.pend_any) begin
               cmd.emit_load = !sts.out_full || sts.out_taken;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/pphd_dp.sv
// Datapath for the peak-hold PWM duty block: levels, countdowns, frame
// tracking, configuration registers, pending result mask and output register.
// Depends on pphd_pkg.
module pphd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pphd_pkg::cmd_type                    cmd,
   output pphd_pkg::sts_type                    sts,
   input  logic                                 req_func,
   input  logic [pphd_pkg::BYTE_BITS-1:0]       req_rx_byte,
   input  logic                                 csr_we,
   input  logic [pphd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pphd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pphd_pkg::CH_BITS-1:0]         rsp_channel,
   output logic [pphd_pkg::DUTY_BITS-1:0]       rsp_duty,
   output logic                                 rsp_last
);

   logic [pphd_pkg::DUTY_BITS-1:0] level_ff [pphd_pkg::CHANNELS];
   logic [pphd_pkg::DUTY_BITS-1:0] level_in [pphd_pkg::CHANNELS];
   logic [pphd_pkg::CD_BITS-1:0]   cd_ff    [pphd_pkg::CHANNELS];
   logic [pphd_pkg::CD_BITS-1:0]   cd_in    [pphd_pkg::CHANNELS];
   logic [pphd_pkg::CHANNELS-1:0]  pend_ff, pend_in;
   logic                           in_frame_ff, in_frame_in;
   logic [pphd_pkg::CH_BITS-1:0]   idx_ff, idx_in;
   logic [pphd_pkg::CD_BITS-1:0]   interval_ff;
   logic [pphd_pkg::BYTE_BITS-1:0] sync_ff;
   logic                           out_valid_ff;
   logic [pphd_pkg::CH_BITS-1:0]   out_ch_ff;
   logic [pphd_pkg::DUTY_BITS-1:0] out_duty_ff;
   logic                           out_last_ff;

   logic [pphd_pkg::DUTY_BITS-1:0] new_val;
   logic [pphd_pkg::DUTY_BITS-1:0] cur_level;
   logic                           raise;
   logic [pphd_pkg::CH_BITS-1:0]   idx_next;
   logic [pphd_pkg::CH_BITS-1:0]   pick_idx;
   logic [pphd_pkg::CHANNELS-1:0]  pick_oh;
   logic [pphd_pkg::CHANNELS-1:0]  pend_left;

   assign new_val   = req_rx_byte[pphd_pkg::DUTY_BITS-1:0];
   assign cur_level = level_ff[idx_ff];
   assign raise     = in_frame_ff && (new_val > cur_level);
   assign idx_next  = idx_ff + 1'b1;

   // Lowest pending channel goes out first.
   always_comb begin
      pick_idx = '0;
      pick_oh  = '0;
      for (int i = pphd_pkg::CHANNELS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick_idx = pphd_pkg::CH_BITS'(i);
            pick_oh  = pphd_pkg::CHANNELS'(1) << i;
         end
      end
   end

   assign pend_left = pend_ff & ~pick_oh;

   always_comb begin
      pend_in     = pend_ff;
      in_frame_in = in_frame_ff;
      idx_in      = idx_ff;
      for (int i = 0; i < pphd_pkg::CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         cd_in[i]    = cd_ff[i];
      end
      if (cmd.emit_load) begin
         pend_in = pend_left;
      end
      if (cmd.accept) begin
         if (req_func == pphd_pkg::FUNC_TICK) begin
            // A countdown of zero or one is due on this tick.
            for (int i = 0; i < pphd_pkg::CHANNELS; i++) begin
               if (cd_ff[i] <= pphd_pkg::CD_BITS'(1)) begin
                  level_in[i] = level_ff[i] >> 1;
                  cd_in[i]    = interval_ff;
                  pend_in[i]  = 1'b1;
               end else begin
                  cd_in[i] = cd_ff[i] - 1'b1;
               end
            end
         end else if (!in_frame_ff) begin
            if (req_rx_byte == sync_ff) begin
               in_frame_in = 1'b1;
               idx_in      = '0;
            end
         end else begin
            if (raise) begin
               level_in[idx_ff] = new_val;
               cd_in[idx_ff]    = interval_ff;
               pend_in[idx_ff]  = 1'b1;
            end
            if (idx_next == pphd_pkg::CH_BITS'(pphd_pkg::CHANNELS)) begin
               in_frame_in = 1'b0;
               idx_in      = '0;
            end else begin
               idx_in = idx_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pphd_pkg::CHANNELS; i++) begin
            level_ff[i] <= '0;
            cd_ff[i]    <= '0;
         end
         pend_ff      <= '0;
         in_frame_ff  <= 1'b0;
         idx_ff       <= '0;
         interval_ff  <= pphd_pkg::RESET_INTERVAL;
         sync_ff      <= pphd_pkg::RESET_SYNC;
         out_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < pphd_pkg::CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
            cd_ff[i]    <= cd_in[i];
         end
         pend_ff     <= pend_in;
         in_frame_ff <= in_frame_in;
         idx_ff      <= idx_in;
         if (csr_we) begin
            case (csr_index)
               pphd_pkg::CSR_DECAY_INTERVAL: begin
                  interval_ff <= csr_wdata[pphd_pkg::CD_BITS-1:0];
               end
               pphd_pkg::CSR_SYNC_BYTE: begin
                  sync_ff <= csr_wdata[pphd_pkg::BYTE_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_ch_ff   <= pick_idx;
         out_duty_ff <= level_ff[pick_idx];
         out_last_ff <= (pend_left == '0);
      end
   end

   assign sts.pend_any  = |pend_ff;
   assign sts.out_full  = out_valid_ff;
   assign sts.out_taken = out_valid_ff && !rsp_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_channel = out_ch_ff;
   assign rsp_duty    = out_duty_ff;
   assign rsp_last    = out_last_ff;

endmodule

// File: rtl/pwm_peak_hold_decay.sv
// Peak-hold PWM duty block with halving decay, top level.
// Instantiates pphd_ctrl and pphd_dp; depends on pphd_pkg.
//
// Each item is either a millisecond tick or a received serial byte. An item is
// applied in its accept cycle: a tick updates all six countdowns and levels at
// once, a frame byte updates at most its one channel. The duty results it
// causes are then sent one per cycle while rsp_stall is low, in ascending
// channel order from an output register. The block stalls new items until
// every result has been loaded into that register, longer while rsp_stall
// holds it. A new item can be taken while the last result still waits in the
// output register. rsp_last marks the final result of an item.
module pwm_peak_hold_decay (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [pphd_pkg::BYTE_BITS-1:0]       req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pphd_pkg::CH_BITS-1:0]         rsp_channel,
   output logic [pphd_pkg::DUTY_BITS-1:0]       rsp_duty,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [pphd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pphd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   pphd_pkg::cmd_type cmd;
   pphd_pkg::sts_type sts;

   pphd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pphd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_channel (rsp_channel),
      .rsp_duty    (rsp_duty),
      .rsp_last    (rsp_last)
   );

endmodule
